// ===== hw/rtl/look_disk_scheduler_defines.svh =====
// -----------------------------------------------------------------------------
// LOOK disk scheduler assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// -----------------------------------------------------------------------------
`ifndef LOOK_DISK_SCHEDULER_DEFINES_SVH
`define LOOK_DISK_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lds assertion failed");
`define LDS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("lds forbidden condition");
`else
`define LDS_ASSERT(lbl, clk, rst_n, prop)
`define LDS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/lds_pkg.sv =====
// -----------------------------------------------------------------------------
// LOOK disk scheduler package
// Shared types and register codes.
// -----------------------------------------------------------------------------
`default_nettype none

package lds_pkg;

  localparam int unsigned TrackW = 10;
  localparam int unsigned MovW   = 11;
  localparam int unsigned SeekW  = 27;
  localparam int unsigned RateW  = 16;
  localparam int unsigned KeyW   = TrackW + 1;

  typedef enum logic [1:0] {
    RegHead = 2'd0,
    RegPrev = 2'd1,
    RegRate = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [TrackW-1:0] head;
    logic [TrackW-1:0] prev;
    logic [RateW-1:0]  rate;
  } cfg_t;

  typedef struct packed {
    logic              bank;
    logic [TrackW-1:0] head;
    logic              down;
    logic [RateW-1:0]  rate;
  } desc_t;

  typedef struct packed {
    logic [TrackW-1:0] served_track;
    logic              last_served;
    logic [MovW-1:0]   total_movement;
    logic [SeekW-1:0]  seek_time;
  } rsp_t;

  typedef struct packed {
    logic busy;
    logic bank;
  } bk_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lds_if.sv =====
// -----------------------------------------------------------------------------
// LOOK disk scheduler stream interfaces
// Valid/ready channels for requests and served tracks.
// -----------------------------------------------------------------------------
`default_nettype none

interface lds_req_if;
  logic       valid;
  logic       ready;
  logic [9:0] track;
  logic       last_request;

  modport source (output valid, output track, output last_request, input ready);
  modport sink   (input valid, input track, input last_request, output ready);
endinterface

interface lds_rsp_if;
  logic        valid;
  logic        ready;
  logic [9:0]  served_track;
  logic        last_served;
  logic [10:0] total_movement;
  logic [26:0] seek_time;

  modport source (output valid, output served_track, output last_served,
                  output total_movement, output seek_time, input ready);
  modport sink   (input valid, input served_track, input last_served,
                  input total_movement, input seek_time, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/look_disk_scheduler.sv =====
// -----------------------------------------------------------------------------
// LOOK disk scheduler
// Collects track requests in batches and returns them in LOOK service order.
// -----------------------------------------------------------------------------
// Usage:
//   req_i carries one track request per transaction; last_request closes the
//   batch, and a batch also closes when it reaches MAX_REQUESTS requests.
//   rsp_o returns every request of the batch in service order; the final
//   transaction carries last_served, total head movement and seek time.
//   head_position, previous_position and seek_rate are written over APB at
//   byte addresses 0, 4 and 8 and are sampled when a batch closes.
// Timing:
//   Loading takes one request per cycle unless req_i stalls. Requests sit in
//   two banks, so one batch loads while the previous one is served. Serving
//   a batch of n requests with k distinct tracks runs a start step, k scans
//   over the bank read port, one result per request, and the StMov and StMul
//   steps for movement and seek time.
//   req_i stalls while a closed batch waits in the queue for the back end.
// Reset:
//   Clears control state and configuration; both banks are free and no batch
//   is pending.
//   When rsp_o stalls, the result is held and emitting pauses.
// -----------------------------------------------------------------------------
`default_nettype none
`include "look_disk_scheduler_defines.svh"

module look_disk_scheduler import lds_pkg::*; #(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lds_req_if.sink     req_i,
  lds_rsp_if.source   rsp_o
);

  localparam int unsigned CntW  = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned IdxW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  cfg_t              cfg_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  logic              fr_push;
  desc_t             fr_desc;
  logic [CntW-1:0]   fr_cnt;
  logic              fr_wr_en;
  logic [IdxW:0]     fr_wr_addr;
  logic [TrackW-1:0] fr_wr_data;
  logic              fr_wr_bank;
  logic              q_full;
  desc_t             q_desc;
  logic [CntW-1:0]   q_cnt;
  logic              bk_pop;
  bk_stat_t          bk_stat;
  rsp_t              bk_rsp;
  logic              bk_rsp_vld;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegHead: cfg_q.head <= pwdata[TrackW-1:0];
        RegPrev: cfg_q.prev <= pwdata[TrackW-1:0];
        RegRate: cfg_q.rate <= pwdata[RateW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegHead: prdata = {22'd0, cfg_q.head};
      RegPrev: prdata = {22'd0, cfg_q.prev};
      RegRate: prdata = {16'd0, cfg_q.rate};
      default: prdata = '0;
    endcase
  end

  lds_front #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (req_i.valid),
    .ready_o   (req_i.ready),
    .track_i   (req_i.track),
    .last_i    (req_i.last_request),
    .cfg_i     (cfg_q),
    .q_full_i  (q_full),
    .push_o    (fr_push),
    .desc_o    (fr_desc),
    .cnt_o     (fr_cnt),
    .wr_en_o   (fr_wr_en),
    .wr_addr_o (fr_wr_addr),
    .wr_data_o (fr_wr_data),
    .wr_bank_o (fr_wr_bank)
  );

  lds_queue #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_push),
    .desc_i (fr_desc),
    .cnt_i  (fr_cnt),
    .pop_i  (bk_pop),
    .full_o (q_full),
    .desc_o (q_desc),
    .cnt_o  (q_cnt)
  );

  lds_back #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (fr_wr_en),
    .wr_addr_i   (fr_wr_addr),
    .wr_data_i   (fr_wr_data),
    .desc_vld_i  (q_full),
    .desc_i      (q_desc),
    .cnt_i       (q_cnt),
    .pop_o       (bk_pop),
    .stat_o      (bk_stat),
    .rsp_valid_o (bk_rsp_vld),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (bk_rsp)
  );

  assign rsp_o.valid          = bk_rsp_vld;
  assign rsp_o.served_track   = bk_rsp.served_track;
  assign rsp_o.last_served    = bk_rsp.last_served;
  assign rsp_o.total_movement = bk_rsp.total_movement;
  assign rsp_o.seek_time      = bk_rsp.seek_time;

  `LDS_ASSERT(a_bank_free, clk_i, rst_ni, fr_wr_en && bk_stat.busy |-> fr_wr_bank != bk_stat.bank)
  `LDS_ASSERT(a_push_room, clk_i, rst_ni, fr_push |-> !q_full || bk_pop)
  `LDS_ASSERT(a_pop_idle, clk_i, rst_ni, bk_pop |=> bk_stat.busy && (bk_stat.bank == $past(q_desc.bank)))
  `LDS_ASSERT_NEVER(a_mid_zero, clk_i, rst_ni, rsp_o.valid && !rsp_o.last_served && (rsp_o.total_movement != 11'd0 || rsp_o.seek_time != 27'd0))

endmodule

`default_nettype wire

// ===== hw/rtl/lds_front.sv =====
// -----------------------------------------------------------------------------
// LOOK disk scheduler front end
// Accepts requests, writes them into the open bank and closes batches.
// -----------------------------------------------------------------------------
`default_nettype none

module lds_front import lds_pkg::*; #(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                valid_i,
  output logic               ready_o,
  input  wire  [TrackW-1:0]  track_i,
  input  wire                last_i,
  input  cfg_t               cfg_i,
  input  wire                q_full_i,
  output logic               push_o,
  output desc_t              desc_o,
  output logic [$clog2(MAX_REQUESTS+1)-1:0] cnt_o,
  output logic               wr_en_o,
  output logic [((MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1):0] wr_addr_o,
  output logic [TrackW-1:0]  wr_data_o,
  output logic               wr_bank_o
);

  localparam int unsigned CntW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned IdxW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  logic [CntW-1:0] fill_q;
  logic            bank_q;
  logic            accept;
  logic            close;
  logic [CntW-1:0] fill_inc;

  assign ready_o   = !q_full_i;
  assign accept    = valid_i && ready_o;
  assign fill_inc  = fill_q + CntW'(1);
  assign close     = last_i || (fill_inc == CntW'(MAX_REQUESTS));

  assign wr_en_o   = accept;
  assign wr_addr_o = {bank_q, fill_q[IdxW-1:0]};
  assign wr_data_o = track_i;
  assign wr_bank_o = bank_q;

  assign push_o      = accept && close;
  assign cnt_o       = fill_inc;
  assign desc_o.bank = bank_q;
  assign desc_o.head = cfg_i.head;
  assign desc_o.down = cfg_i.head < cfg_i.prev;
  assign desc_o.rate = cfg_i.rate;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bank_q <= 1'b0;
    end else if (accept) begin
      if (close) begin
        fill_q <= '0;
        bank_q <= !bank_q;
      end else begin
        fill_q <= fill_inc;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lds_queue.sv =====
// -----------------------------------------------------------------------------
// LOOK disk scheduler batch queue
// One-entry queue of closed batches between front end and back end.
// -----------------------------------------------------------------------------
`default_nettype none

module lds_queue import lds_pkg::*; #(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                push_i,
  input  desc_t                              desc_i,
  input  wire  [$clog2(MAX_REQUESTS+1)-1:0]  cnt_i,
  input  wire                                pop_i,
  output logic                               full_o,
  output desc_t                              desc_o,
  output logic [$clog2(MAX_REQUESTS+1)-1:0]  cnt_o
);

  localparam int unsigned CntW = $clog2(MAX_REQUESTS + 1);

  logic            vld_q;
  desc_t           desc_q;
  logic [CntW-1:0] cnt_q;

  assign full_o = vld_q;
  assign desc_o = desc_q;
  assign cnt_o  = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= push_i || (vld_q && !pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      desc_q <= desc_i;
      cnt_q  <= cnt_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lds_back.sv =====
// -----------------------------------------------------------------------------
// LOOK disk scheduler back end
// Holds the request banks and emits each batch in LOOK service order by
// repeated minimum-key scans over the stored requests.
// -----------------------------------------------------------------------------
`default_nettype none

module lds_back import lds_pkg::*; #(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                wr_en_i,
  input  wire  [((MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1):0] wr_addr_i,
  input  wire  [TrackW-1:0]                  wr_data_i,
  input  wire                                desc_vld_i,
  input  desc_t                              desc_i,
  input  wire  [$clog2(MAX_REQUESTS+1)-1:0]  cnt_i,
  output logic                               pop_o,
  output bk_stat_t                           stat_o,
  output logic                               rsp_valid_o,
  input  wire                                rsp_ready_i,
  output rsp_t                               rsp_o
);

  localparam int unsigned CntW  = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned IdxW  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned AddrW = IdxW + 1;
  localparam int unsigned Depth = 2 ** AddrW;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StMov  = 5'b00100,
    StMul  = 5'b01000,
    StEmit = 5'b10000
  } bk_state_e;

  logic [TrackW-1:0] mem [Depth];
  logic [TrackW-1:0] rd_data_q;
  logic [AddrW-1:0]  rd_addr;
  logic              rd_en;

  bk_state_e         state_q;
  logic              bank_q;
  logic [TrackW-1:0] head_q;
  logic              down_q;
  logic [RateW-1:0]  rate_q;
  logic [CntW-1:0]   n_q;
  logic [CntW-1:0]   rd_idx_q;
  logic              rd_vld_q;
  logic [CntW-1:0]   done_q;
  logic [CntW-1:0]   rep_q;
  logic [KeyW-1:0]   prev_key_q;
  logic              prev_vld_q;
  logic [KeyW-1:0]   best_key_q;
  logic [CntW-1:0]   best_cnt_q;
  logic              found_q;
  logic [TrackW-1:0] d1_q;
  logic [TrackW-1:0] d2_q;
  logic              have1_q;
  logic              have2_q;
  logic [MovW-1:0]   mov_q;
  logic [SeekW-1:0]  st_q;
  logic              rsp_vld_q;
  rsp_t              rsp_q;

  logic              t_ge;
  logic              t_le;
  logic [TrackW-1:0] trk_gap;
  logic [KeyW-1:0]   key;
  logic              qual;
  logic              scan_end;
  logic              last_key;
  logic              is_last;
  logic              plus;
  logic [TrackW-1:0] out_track;
  logic              out_free;

  assign rd_en   = (state_q == StScan) && (rd_idx_q < n_q);
  assign rd_addr = {bank_q, rd_idx_q[IdxW-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign t_ge     = rd_data_q >= head_q;
  assign t_le     = rd_data_q <= head_q;
  assign trk_gap  = t_ge ? (rd_data_q - head_q) : (head_q - rd_data_q);
  assign key      = {(down_q ? !t_le : !t_ge), trk_gap};
  assign qual     = rd_vld_q && (!prev_vld_q || (key > prev_key_q));
  assign scan_end = (rd_idx_q == n_q) && !rd_vld_q;
  assign last_key = ({1'b0, done_q} + {1'b0, best_cnt_q}) == {1'b0, n_q};

  assign is_last   = (done_q + CntW'(1)) == n_q;
  assign plus      = down_q == prev_key_q[KeyW-1];
  assign out_track = plus ? (head_q + prev_key_q[TrackW-1:0])
                          : (head_q - prev_key_q[TrackW-1:0]);
  assign out_free  = !rsp_vld_q || rsp_ready_i;

  assign pop_o       = (state_q == StIdle) && desc_vld_i;
  assign stat_o.busy = state_q != StIdle;
  assign stat_o.bank = bank_q;
  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      rsp_vld_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      done_q     <= '0;
      rep_q      <= '0;
      n_q        <= '0;
      found_q    <= 1'b0;
      prev_vld_q <= 1'b0;
      have1_q    <= 1'b0;
      have2_q    <= 1'b0;
    end else begin
      rd_vld_q  <= rd_en;
      rsp_vld_q <= ((state_q == StEmit) && out_free) || (rsp_vld_q && !rsp_ready_i);
      case (state_q)
        StIdle: begin
          if (desc_vld_i) begin
            n_q        <= cnt_i;
            rd_idx_q   <= '0;
            done_q     <= '0;
            found_q    <= 1'b0;
            prev_vld_q <= 1'b0;
            have1_q    <= 1'b0;
            have2_q    <= 1'b0;
            state_q    <= StScan;
          end
        end
        StScan: begin
          if (rd_en) begin
            rd_idx_q <= rd_idx_q + CntW'(1);
          end
          if (qual) begin
            if (!found_q || (key < best_key_q)) begin
              found_q    <= 1'b1;
              best_cnt_q <= CntW'(1);
            end else if (key == best_key_q) begin
              best_cnt_q <= best_cnt_q + CntW'(1);
            end
          end
          if (scan_end) begin
            prev_vld_q <= 1'b1;
            rep_q      <= best_cnt_q;
            if (best_key_q[KeyW-1]) begin
              have2_q <= 1'b1;
            end else begin
              have1_q <= 1'b1;
            end
            state_q <= last_key ? StMov : StEmit;
          end
        end
        StMov: begin
          state_q <= StMul;
        end
        StMul: begin
          state_q <= StEmit;
        end
        StEmit: begin
          if (out_free) begin
            done_q    <= done_q + CntW'(1);
            rep_q     <= rep_q - CntW'(1);
            if (rep_q == CntW'(1)) begin
              if (is_last) begin
                state_q <= StIdle;
              end else begin
                rd_idx_q <= '0;
                found_q  <= 1'b0;
                state_q  <= StScan;
              end
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bank_q <= desc_i.bank;
      head_q <= desc_i.head;
      down_q <= desc_i.down;
      rate_q <= desc_i.rate;
    end
    if (state_q == StScan) begin
      if (qual && (!found_q || (key < best_key_q))) begin
        best_key_q <= key;
      end
      if (scan_end) begin
        prev_key_q <= best_key_q;
        if (best_key_q[KeyW-1]) begin
          d2_q <= best_key_q[TrackW-1:0];
        end else begin
          d1_q <= best_key_q[TrackW-1:0];
        end
      end
    end
    if (state_q == StMov) begin
      if (have1_q && have2_q) begin
        mov_q <= {d1_q, 1'b0} + {1'b0, d2_q};
      end else if (have1_q) begin
        mov_q <= {1'b0, d1_q};
      end else begin
        mov_q <= {1'b0, d2_q};
      end
    end
    if (state_q == StMul) begin
      st_q <= SeekW'(mov_q) * SeekW'(rate_q);
    end
    if ((state_q == StEmit) && out_free) begin
      rsp_q.served_track   <= out_track;
      rsp_q.last_served    <= is_last;
      rsp_q.total_movement <= is_last ? mov_q : '0;
      rsp_q.seek_time      <= is_last ? st_q : '0;
    end
  end

endmodule

`default_nettype wire

// ===== test/look_disk_scheduler_tb.sv =====
// -----------------------------------------------------------------------------
// LOOK disk scheduler testbench
// Drives track requests in batches and checks each served track against a
// LOOK sweep predictor, or a fixed expectation for typed directed steps; the
// predictor covers service order, head movement and seek time. A directed
// table runs first, then random batches with APB register changes between
// them. Both streams idle at random; the result side also has one long hold.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module look_disk_scheduler_tb;
  import lds_pkg::*;

  localparam int unsigned MaxRequests   = 32;
  localparam int unsigned RandomItems   = 270;
  localparam int unsigned QuietItems    = 40;
  localparam int unsigned LongHold      = 600;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned PrintLimit    = 100;

  typedef enum logic {DoRequest, DoWrite} step_kind_e;

  typedef struct packed {
    step_kind_e        kind;
    reg_idx_e          sel;
    logic [31:0]       wdata;
    logic [TrackW-1:0] trk;
    logic              last;
    logic              typed;
    rsp_t              want;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lds_req_if req ();
  lds_rsp_if rsp ();

  look_disk_scheduler #(.MAX_REQUESTS(MaxRequests)) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req),
    .rsp_o   (rsp)
  );

  rsp_t              service_order_q [$];
  logic [TrackW-1:0] loading_tracks [$];
  logic [TrackW-1:0] head_trk;
  logic [TrackW-1:0] prev_trk;
  logic [RateW-1:0]  rate_per_trk;
  int                mismatches  = 0;
  int                idle_cycles = 0;
  bit                quiet       = 1'b0;
  bit                long_hold_go = 1'b0;

  step_t directed_steps [22] = '{
    '{DoRequest, RegHead, 32'd0, 10'd0, 1'b1, 1'b1, '{10'd0, 1'b1, 11'd0, 27'd0}},
    '{DoRequest, RegHead, 32'd0, 10'd1023, 1'b1, 1'b1, '{10'd1023, 1'b1, 11'd1023, 27'd0}},
    '{DoWrite, RegRate, 32'd65535, 10'd0, 1'b0, 1'b0, '0},
    '{DoWrite, RegHead, 32'd1023, 10'd0, 1'b0, 1'b0, '0},
    '{DoRequest, RegHead, 32'd0, 10'd0, 1'b1, 1'b1,
      '{10'd0, 1'b1, 11'd1023, 27'd67042305}},
    '{DoRequest, RegHead, 32'd0, 10'd1023, 1'b1, 1'b1, '{10'd1023, 1'b1, 11'd0, 27'd0}},
    '{DoWrite, RegPrev, 32'd1023, 10'd0, 1'b0, 1'b0, '0},
    '{DoWrite, RegHead, 32'd0, 10'd0, 1'b0, 1'b0, '0},
    '{DoRequest, RegHead, 32'd0, 10'd1023, 1'b1, 1'b1,
      '{10'd1023, 1'b1, 11'd1023, 27'd67042305}},
    '{DoWrite, RegHead, 32'hFFFF_FE00, 10'd0, 1'b0, 1'b0, '0},
    '{DoRequest, RegHead, 32'd0, 10'd600, 1'b0, 1'b0, '0},
    '{DoRequest, RegHead, 32'd0, 10'd100, 1'b0, 1'b0, '0},
    '{DoRequest, RegHead, 32'd0, 10'd512, 1'b0, 1'b0, '0},
    '{DoRequest, RegHead, 32'd0, 10'd100, 1'b0, 1'b0, '0},
    '{DoRequest, RegHead, 32'd0, 10'd0, 1'b1, 1'b0, '0},
    '{DoWrite, RegPrev, 32'd512, 10'd0, 1'b0, 1'b0, '0},
    '{DoWrite, RegRate, 32'd3, 10'd0, 1'b0, 1'b0, '0},
    '{DoRequest, RegHead, 32'd0, 10'd300, 1'b0, 1'b0, '0},
    '{DoRequest, RegHead, 32'd0, 10'd700, 1'b0, 1'b0, '0},
    '{DoRequest, RegHead, 32'd0, 10'd512, 1'b0, 1'b0, '0},
    '{DoRequest, RegHead, 32'd0, 10'd1023, 1'b0, 1'b0, '0},
    '{DoRequest, RegHead, 32'd0, 10'd5, 1'b1, 1'b0, '0}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PrintLimit) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  function automatic void plan_look_sweep();
    logic [TrackW-1:0] srt [$];
    logic [TrackW-1:0] order [$];
    logic [TrackW-1:0] v;
    rsp_t              r;
    int                j;
    int                far_a;
    int                far_b;
    int                mov;
    int                seek;
    bit                down;
    bit                got_a;
    bit                got_b;
    far_a = 0;
    far_b = 0;
    got_a = 1'b0;
    got_b = 1'b0;
    foreach (loading_tracks[i]) begin
      v = loading_tracks[i];
      j = srt.size();
      srt.push_back(v);
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    down = head_trk < prev_trk;
    if (down) begin
      for (int i = srt.size() - 1; i >= 0; i--) begin
        if (srt[i] <= head_trk) begin
          order.push_back(srt[i]);
          far_a = srt[i];
          got_a = 1'b1;
        end
      end
      for (int i = 0; i < srt.size(); i++) begin
        if (srt[i] > head_trk) begin
          order.push_back(srt[i]);
          far_b = srt[i];
          got_b = 1'b1;
        end
      end
      if (got_a) mov = (int'(head_trk) - far_a) + (got_b ? far_b - far_a : 0);
      else mov = got_b ? far_b - int'(head_trk) : 0;
    end else begin
      for (int i = 0; i < srt.size(); i++) begin
        if (srt[i] >= head_trk) begin
          order.push_back(srt[i]);
          far_a = srt[i];
          got_a = 1'b1;
        end
      end
      for (int i = srt.size() - 1; i >= 0; i--) begin
        if (srt[i] < head_trk) begin
          order.push_back(srt[i]);
          far_b = srt[i];
          got_b = 1'b1;
        end
      end
      if (got_a) mov = (far_a - int'(head_trk)) + (got_b ? far_a - far_b : 0);
      else mov = got_b ? int'(head_trk) - far_b : 0;
    end
    seek = mov * int'(rate_per_trk);
    foreach (order[k]) begin
      r.served_track   = order[k];
      r.last_served    = (k == order.size() - 1);
      r.total_movement = r.last_served ? mov[MovW-1:0] : '0;
      r.seek_time      = r.last_served ? seek[SeekW-1:0] : '0;
      service_order_q.push_back(r);
    end
    loading_tracks.delete();
  endfunction

  function automatic void note_request(input logic [TrackW-1:0] trk, input logic last);
    loading_tracks.push_back(trk);
    if (last || loading_tracks.size() == MaxRequests) plan_look_sweep();
  endfunction

  task automatic check_result();
    rsp_t want;
    if (service_order_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result, track %0d", rsp.served_track));
    end else begin
      want = service_order_q.pop_front();
      if (rsp.served_track !== want.served_track)
        report_mismatch($sformatf("served_track %0d, want %0d",
                                  rsp.served_track, want.served_track));
      if (rsp.last_served !== want.last_served)
        report_mismatch($sformatf("last_served %0b, want %0b",
                                  rsp.last_served, want.last_served));
      if (rsp.total_movement !== want.total_movement)
        report_mismatch($sformatf("total_movement %0d, want %0d",
                                  rsp.total_movement, want.total_movement));
      if (rsp.seek_time !== want.seek_time)
        report_mismatch($sformatf("seek_time %0d, want %0d",
                                  rsp.seek_time, want.seek_time));
    end
  endtask

  task automatic offer_request(input logic [TrackW-1:0] trk, input logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.track        <= trk;
    req.last_request <= last;
    do @(posedge clk_i); while (req.ready !== 1'b1);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (service_order_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e sel, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      RegHead: head_trk     = val[TrackW-1:0];
      RegPrev: prev_trk     = val[TrackW-1:0];
      RegRate: rate_per_trk = val[RateW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [TrackW-1:0] pick_track();
    logic [TrackW-1:0] near;
    near = head_trk + TrackW'($urandom_range(0, 2)) - TrackW'(1);
    case ($urandom_range(0, 8))
      0: return head_trk;
      1: return near;
      2: return '0;
      3: return '1;
      4, 5: begin
        if (loading_tracks.size() != 0)
          return loading_tracks[$urandom_range(0, loading_tracks.size() - 1)];
        return TrackW'($urandom_range(0, 1023));
      end
      default: return TrackW'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin : result_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (rsp.valid && rsp.ready) check_result();
        if (hold_left > 0) begin
          hold_left--;
          rsp.ready <= 1'b0;
        end else if (long_hold_go && !hold_done) begin
          hold_done = 1'b1;
          hold_left = LongHold - 1;
          rsp.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          hold_left = $urandom_range(0, 4);
          rsp.ready <= 1'b0;
        end else begin
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : request_source
    int                sent;
    int                size;
    logic [TrackW-1:0] trk;
    logic              last;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req.valid        = 1'b0;
    req.track        = '0;
    req.last_request = 1'b0;
    head_trk         = '0;
    prev_trk         = '0;
    rate_per_trk     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[s]) begin
      if (directed_steps[s].kind == DoWrite) begin
        wait_drained();
        write_reg(directed_steps[s].sel, directed_steps[s].wdata);
      end else begin
        offer_request(directed_steps[s].trk, directed_steps[s].last);
        if (directed_steps[s].typed) service_order_q.push_back(directed_steps[s].want);
        else note_request(directed_steps[s].trk, directed_steps[s].last);
      end
    end

    sent = 0;
    while (sent < RandomItems) begin
      quiet = (sent >= RandomItems - QuietItems);
      if (sent >= 90 && !long_hold_go) long_hold_go = 1'b1;
      if ((sent < 80 || (sent > 160 && !quiet)) && $urandom_range(0, 3) == 0) begin
        wait_drained();
        if ($urandom_range(0, 1)) write_reg(RegHead, pick_reg_value());
        if ($urandom_range(0, 1)) write_reg(RegPrev, pick_reg_value());
        if ($urandom_range(0, 1)) write_reg(RegRate, pick_reg_value());
      end
      case ($urandom_range(0, 11))
        0:       size = MaxRequests;
        1:       size = 1;
        default: size = $urandom_range(2, 8);
      endcase
      for (int k = 0; k < size; k++) begin
        trk = pick_track();
        if (k != size - 1) last = 1'b0;
        else if (size == MaxRequests) last = $urandom_range(0, 1);
        else last = 1'b1;
        offer_request(trk, last);
        note_request(trk, last);
        sent++;
      end
    end

    req.valid <= 1'b0;
    while (service_order_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
